// ===== src/rope_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary embedding package
// Shared constants, configuration register indexes, reset values and the
// constant tables used by the rotary embedding pipeline.
// ----------------------------------------------------------------------------
package rope_pkg;

	localparam int HEAD_PAIRS_DEF    = 64;
	localparam int DATA_WIDTH_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int POS_W    = 16;
	localparam int IDX_W    = 6;
	localparam int STEP_W   = 20;
	localparam int RPAIRS_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_PAIRS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_OFFSET = 2'd2;

	localparam logic [STEP_W-1:0]   FREQ_STEP_RESET  = 20'd13607;
	localparam logic [RPAIRS_W-1:0] ROT_PAIRS_RESET  = 7'd64;
	localparam logic [POS_W-1:0]    POS_OFFSET_RESET = 16'd0;

	// Fraction bits of the frequency exponent, one mantissa stage each.
	localparam int MANT_BITS = 16;
	// Internal CORDIC datapath width (Q1.30 plus headroom).
	localparam int CW = 34;
	localparam int ATAN_ENTRIES = 24;

	localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

	typedef logic [31:0] atan_tab_t [0:ATAN_ENTRIES-1];
	localparam atan_tab_t ATAN_TURNS = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Roots 2^(-2^-k) in Q0.32, each the integer square root of the previous
	// one scaled by 2^32. Evaluated at elaboration only.
	typedef logic [31:0] root_tab_t [0:MANT_BITS];

	function automatic longint unsigned isqrt64(input longint unsigned n_in);
		longint unsigned n;
		longint unsigned res;
		longint unsigned b;
		n   = n_in;
		res = 0;
		b   = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + b) begin
				n   = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic root_tab_t build_roots();
		root_tab_t t;
		longint unsigned v;
		v = 64'h8000_0000;
		t[0] = v[31:0];
		for (int k = 1; k <= MANT_BITS; k++) begin
			v = isqrt64(v << 32);
			t[k] = v[31:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOT_TABLE = build_roots();

endpackage

// ===== src/rotary_position_embedding_pair_top.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle while out_ready accepts results; every
// multiply and CORDIC step has its own pipeline register, so the rate is one
// stage advance per clock unless the output stalls.
// Reset: arst_n clears all valid bits and loads the register reset values;
// the datapath registers are not reset.
// ----------------------------------------------------------------------------
// Rotary position embedding, one element pair per item
// Rotates a Q3.12 pair by (offset + position) * 2^(-index*step) turns/2pi,
// using a pipelined power-of-two mantissa chain, phase reduction modulo one
// turn and a pipelined CORDIC. Pairs beyond the rotary count or HEAD_PAIRS pass through.
// ----------------------------------------------------------------------------
module rotary_position_embedding_pair_top import rope_pkg::*; #(
	parameter int HEAD_PAIRS    = HEAD_PAIRS_DEF,
	parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write port.
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	// Input item channel.
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [POS_W-1:0]             position,
	input  logic [IDX_W-1:0]             pair_index,
	input  logic signed [DATA_WIDTH-1:0] x_first,
	input  logic signed [DATA_WIDTH-1:0] x_second,
	// Result item channel.
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] y_first,
	output logic signed [DATA_WIDTH-1:0] y_second
);

	// The CORDIC is limited by the size of the arctangent table.
	localparam int CS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

	// Stage numbering of the whole pipeline. Each stage has one valid bit and
	// one enable; the mantissa and CORDIC chains occupy a run of stages each.
	localparam int ST_PREP = 0;
	localparam int ST_MANT = 1;
	localparam int ST_A    = ST_MANT + MANT_BITS;
	localparam int ST_LOHI = ST_A + 1;
	localparam int ST_PH   = ST_LOHI + 1;
	localparam int ST_QR   = ST_PH + 1;
	localparam int ST_CORD = ST_QR + 1;
	localparam int ST_QUAD = ST_CORD + CS;
	localparam int ST_PROD = ST_QUAD + 1;
	localparam int ST_OUT  = ST_PROD + 1;
	localparam int N_ST    = ST_OUT + 1;

	localparam int P_W   = POS_W + 1;
	localparam int E_W   = IDX_W + STEP_W;
	localparam int EI_W  = E_W - MANT_BITS;
	localparam int PXS_W = 1 + 2 * DATA_WIDTH;
	localparam int MSIDE_W = P_W + EI_W + PXS_W;
	localparam int CSIDE_W = 2 + PXS_W;
	localparam int PR_W  = DATA_WIDTH + CW;
	localparam int T_W   = PR_W + 2;

	localparam logic signed [T_W-1:0] SAT_MAX = T_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
	localparam logic signed [T_W-1:0] SAT_MIN = -SAT_MAX - T_W'(1);

	// ---------------------------------------------------------------- config
	logic [STEP_W-1:0]   freq_step_q;
	logic [RPAIRS_W-1:0] rot_pairs_q;
	logic [POS_W-1:0]    pos_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_step_q  <= FREQ_STEP_RESET;
			rot_pairs_q  <= ROT_PAIRS_RESET;
			pos_offset_q <= POS_OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FREQ_STEP:  freq_step_q  <= cfg_data[STEP_W-1:0];
				CFG_ROT_PAIRS:  rot_pairs_q  <= cfg_data[RPAIRS_W-1:0];
				CFG_POS_OFFSET: pos_offset_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------ flow control
	// A stage may load when it is empty or when the stage after it moves on,
	// so bubbles close up and a waiting result blocks the input only once every stage is full.
	logic [N_ST-1:0] vld_q;
	logic [N_ST:0]   en;
	logic [N_ST-1:0] vld_in;

	always_comb begin
		en[N_ST] = out_ready;
		for (int i = N_ST - 1; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vld_in = {vld_q[N_ST-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < N_ST; i++) begin
				if (en[i]) vld_q[i] <= vld_in[i];
			end
		end
	end

	assign in_ready  = en[ST_PREP];
	assign out_valid = vld_q[N_ST-1];

	// ------------------------------------------------ stage: preparation
	// Position sum, frequency exponent and the pass-through decision.
	logic [P_W-1:0]       p_s1;
	logic [E_W-1:0]       e_s1;
	logic [PXS_W-1:0]     pxs_s1;
	logic                 pass_now;

	assign pass_now = ({1'b0, pair_index} >= rot_pairs_q)
		|| (32'(pair_index) >= 32'(HEAD_PAIRS));

	always_ff @(posedge clk) begin
		if (en[ST_PREP]) begin
			p_s1   <= P_W'(position) + P_W'(pos_offset_q);
			e_s1   <= E_W'(pair_index) * E_W'(freq_step_q);
			pxs_s1 <= {pass_now, x_first, x_second};
		end
	end

	// ------------------------------------------------ stage: mantissa chain
	logic [31:0]          m_s2;
	logic [MSIDE_W-1:0]   mside_s2;

	rope_mant #(
		.SIDE_W (MSIDE_W)
	) u_mant (
		.clk      (clk),
		.en       (en[ST_MANT +: MANT_BITS]),
		.ef_in    (e_s1[MANT_BITS-1:0]),
		.side_in  ({p_s1, e_s1[E_W-1:MANT_BITS], pxs_s1}),
		.m_out    (m_s2),
		.side_out (mside_s2)
	);

	// ------------------------------------------------ stage: position times frequency
	logic [P_W+31:0]  a_s3;
	logic [EI_W-1:0]  ei_s3;
	logic [PXS_W-1:0] pxs_s3;

	always_ff @(posedge clk) begin
		if (en[ST_A]) begin
			a_s3   <= (P_W+32)'(mside_s2[MSIDE_W-1 -: P_W]) * (P_W+32)'(m_s2);
			ei_s3  <= mside_s2[PXS_W +: EI_W];
			pxs_s3 <= mside_s2[PXS_W-1:0];
		end
	end

	// ------------------------------------------------ stage: scale by 1/(2 pi)
	// The 49-bit product is split into two partial products.
	logic [61:0]      lo_s4;
	logic [P_W+29:0]  hi_s4;
	logic [EI_W-1:0]  ei_s4;
	logic [PXS_W-1:0] pxs_s4;

	always_ff @(posedge clk) begin
		if (en[ST_LOHI]) begin
			lo_s4  <= 62'(a_s3[31:0]) * 62'(INV_TWO_PI_Q32);
			hi_s4  <= (P_W+30)'(a_s3[P_W+31:32]) * (P_W+30)'(INV_TWO_PI_Q32);
			ei_s4  <= ei_s3;
			pxs_s4 <= pxs_s3;
		end
	end

	// ------------------------------------------------ stage: phase in turns
	logic [63:0]      y_full;
	logic [31:0]      ph_s5;
	logic [PXS_W-1:0] pxs_s5;

	assign y_full = ({hi_s4, 1'b0} + 64'(lo_s4[61:31])) >> ei_s4[5:0];

	always_ff @(posedge clk) begin
		if (en[ST_PH]) begin
			ph_s5  <= (ei_s4 >= EI_W'(64)) ? 32'd0 : y_full[31:0];
			pxs_s5 <= pxs_s4;
		end
	end

	// ------------------------------------------------ stage: quadrant split
	// Nearest quarter turn and the remainder within one eighth of a turn.
	logic [32:0]          ph_rnd;
	logic [2:0]           quad_now;
	logic signed [CW-1:0] z_s6;
	logic [CSIDE_W-1:0]   cside_s6;

	assign ph_rnd   = 33'(ph_s5) + 33'h2000_0000;
	assign quad_now = ph_rnd[32:30];

	always_ff @(posedge clk) begin
		if (en[ST_QR]) begin
			z_s6     <= $signed(CW'(ph_s5)) - $signed({1'b0, quad_now, 30'd0});
			cside_s6 <= {quad_now[1:0], pxs_s5};
		end
	end

	// ------------------------------------------------ stage: CORDIC
	logic signed [CW-1:0] cx_s7, cy_s7;
	logic [CSIDE_W-1:0]   cside_s7;

	rope_cordic #(
		.STAGES (CS),
		.SIDE_W (CSIDE_W)
	) u_cordic (
		.clk      (clk),
		.en       (en[ST_CORD +: CS]),
		.z_in     (z_s6),
		.side_in  (cside_s6),
		.cx_out   (cx_s7),
		.cy_out   (cy_s7),
		.side_out (cside_s7)
	);

	// ------------------------------------------------ stage: quadrant map
	logic signed [CW-1:0] c_s8, s_s8;
	logic [PXS_W-1:0]     pxs_s8;

	always_ff @(posedge clk) begin
		if (en[ST_QUAD]) begin
			case (cside_s7[CSIDE_W-1 -: 2])
				2'd0: begin c_s8 <= cx_s7;  s_s8 <= cy_s7;  end
				2'd1: begin c_s8 <= -cy_s7; s_s8 <= cx_s7;  end
				2'd2: begin c_s8 <= -cx_s7; s_s8 <= -cy_s7; end
				default: begin c_s8 <= cy_s7; s_s8 <= -cx_s7; end
			endcase
			pxs_s8 <= cside_s7[PXS_W-1:0];
		end
	end

	// ------------------------------------------------ stage: products
	logic signed [DATA_WIDTH-1:0] x0_s8, x1_s8;
	logic signed [PR_W-1:0] x0c_s9, x1s_s9, x0s_s9, x1c_s9;
	logic [PXS_W-1:0]       pxs_s9;

	assign x0_s8 = $signed(pxs_s8[2*DATA_WIDTH-1:DATA_WIDTH]);
	assign x1_s8 = $signed(pxs_s8[DATA_WIDTH-1:0]);

	always_ff @(posedge clk) begin
		if (en[ST_PROD]) begin
			x0c_s9 <= PR_W'(x0_s8) * PR_W'(c_s8);
			x1s_s9 <= PR_W'(x1_s8) * PR_W'(s_s8);
			x0s_s9 <= PR_W'(x0_s8) * PR_W'(s_s8);
			x1c_s9 <= PR_W'(x1_s8) * PR_W'(c_s8);
			pxs_s9 <= pxs_s8;
		end
	end

	// ------------------------------------------------ stage: round, saturate
	logic signed [T_W-1:0] t_first, t_second, sh_first, sh_second;
	logic signed [DATA_WIDTH-1:0] sat_first, sat_second;
	logic signed [DATA_WIDTH-1:0] y_first_s10, y_second_s10;

	assign t_first   = T_W'(x0c_s9) - T_W'(x1s_s9) + T_W'(64'sd1 <<< 29);
	assign t_second  = T_W'(x0s_s9) + T_W'(x1c_s9) + T_W'(64'sd1 <<< 29);
	assign sh_first  = t_first >>> 30;
	assign sh_second = t_second >>> 30;

	always_comb begin
		if (sh_first > SAT_MAX)       sat_first = DATA_WIDTH'(SAT_MAX);
		else if (sh_first < SAT_MIN)  sat_first = DATA_WIDTH'(SAT_MIN);
		else                          sat_first = DATA_WIDTH'(sh_first);
		if (sh_second > SAT_MAX)      sat_second = DATA_WIDTH'(SAT_MAX);
		else if (sh_second < SAT_MIN) sat_second = DATA_WIDTH'(SAT_MIN);
		else                          sat_second = DATA_WIDTH'(sh_second);
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			if (pxs_s9[PXS_W-1]) begin
				y_first_s10  <= $signed(pxs_s9[2*DATA_WIDTH-1:DATA_WIDTH]);
				y_second_s10 <= $signed(pxs_s9[DATA_WIDTH-1:0]);
			end else begin
				y_first_s10  <= sat_first;
				y_second_s10 <= sat_second;
			end
		end
	end

	assign y_first  = y_first_s10;
	assign y_second = y_second_s10;

endmodule

// ===== src/rope_mant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency mantissa chain
// Forms 2^(-fraction) in Q1.31, one fraction bit and one multiply per stage.
// ----------------------------------------------------------------------------
module rope_mant import rope_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic [MANT_BITS-1:0] en,
	input  logic [MANT_BITS-1:0] ef_in,
	input  logic [SIDE_W-1:0]    side_in,
	output logic [31:0]          m_out,
	output logic [SIDE_W-1:0]    side_out
);

	logic [31:0]          m_s    [1:MANT_BITS];
	logic [MANT_BITS-1:0] ef_s   [1:MANT_BITS];
	logic [SIDE_W-1:0]    side_s [1:MANT_BITS];

	for (genvar k = 1; k <= MANT_BITS; k++) begin : g_stage
		logic [31:0]          m_prev;
		logic [MANT_BITS-1:0] ef_prev;
		logic [SIDE_W-1:0]    side_prev;
		logic [63:0]          prod;

		if (k == 1) begin : g_first
			assign m_prev    = 32'h8000_0000;
			assign ef_prev   = ef_in;
			assign side_prev = side_in;
		end else begin : g_next
			assign m_prev    = m_s[k-1];
			assign ef_prev   = ef_s[k-1];
			assign side_prev = side_s[k-1];
		end

		// Rounded product of the mantissa and this stage's root.
		assign prod = 64'(m_prev) * 64'(ROOT_TABLE[k]) + 64'h8000_0000;

		always_ff @(posedge clk) begin
			if (en[k-1]) begin
				m_s[k]    <= ef_prev[MANT_BITS-k] ? prod[63:32] : m_prev;
				ef_s[k]   <= ef_prev;
				side_s[k] <= side_prev;
			end
		end
	end

	assign m_out    = m_s[MANT_BITS];
	assign side_out = side_s[MANT_BITS];

endmodule

// ===== src/rope_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Pipelined circular CORDIC, one micro-rotation per stage, angle in turns.
// ----------------------------------------------------------------------------
module rope_cordic import rope_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic [STAGES-1:0]    en,
	input  logic signed [CW-1:0] z_in,
	input  logic [SIDE_W-1:0]    side_in,
	output logic signed [CW-1:0] cx_out,
	output logic signed [CW-1:0] cy_out,
	output logic [SIDE_W-1:0]    side_out
);

	logic signed [CW-1:0] cx_s   [0:STAGES-1];
	logic signed [CW-1:0] cy_s   [0:STAGES-1];
	logic signed [CW-1:0] z_s    [0:STAGES-1];
	logic [SIDE_W-1:0]    side_s [0:STAGES-1];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [CW-1:0] cx_prev, cy_prev, z_prev, dx, dy, at;
		logic [SIDE_W-1:0]    side_prev;

		if (i == 0) begin : g_first
			assign cx_prev   = $signed(CW'(CORDIC_GAIN_Q30));
			assign cy_prev   = '0;
			assign z_prev    = z_in;
			assign side_prev = side_in;
		end else begin : g_next
			assign cx_prev   = cx_s[i-1];
			assign cy_prev   = cy_s[i-1];
			assign z_prev    = z_s[i-1];
			assign side_prev = side_s[i-1];
		end

		assign dx = cy_prev >>> i;
		assign dy = cx_prev >>> i;
		assign at = $signed(CW'(ATAN_TURNS[i]));

		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (!z_prev[CW-1]) begin
					cx_s[i] <= cx_prev - dx;
					cy_s[i] <= cy_prev + dy;
					z_s[i]  <= z_prev - at;
				end else begin
					cx_s[i] <= cx_prev + dx;
					cy_s[i] <= cy_prev - dy;
					z_s[i]  <= z_prev + at;
				end
				side_s[i] <= side_prev;
			end
		end
	end

	assign cx_out   = cx_s[STAGES-1];
	assign cy_out   = cy_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule
